// ===== hdl/mad_pkg.sv =====
// Package: shared types and constants of the arithmetic multiply/divide unit.
package mad_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned DIV_STAGES = XLEN;
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_ADDI  = 3'd2,
    OP_MULT  = 3'd3,
    OP_MULTU = 3'd4,
    OP_DIV   = 3'd5,
    OP_DIVU  = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ALU  = 2'd1,
    KIND_MUL  = 2'd2,
    KIND_DIV  = 2'd3
  } kind_e;

  // classified operation handed from front to back
  typedef struct packed {
    kind_e            kind;
    logic [XLEN-1:0]  mag_a;
    logic [XLEN-1:0]  mag_b;
    logic             neg_hi;
    logic             neg_lo;
    logic             k0_write;
    logic             k0_value;
    logic             gpr_write;
    logic [4:0]       gpr_index;
    logic [XLEN-1:0]  gpr_value;
    logic             hilo_write;
  } entry_t;

  // payload of one back-end pipeline stage
  typedef struct packed {
    kind_e             kind;
    logic [2*XLEN-1:0] rq;
    logic [XLEN-1:0]   divisor;
    logic              neg_hi;
    logic              neg_lo;
    logic              k0_write;
    logic              k0_value;
    logic              gpr_write;
    logic [4:0]        gpr_index;
    logic [XLEN-1:0]   gpr_value;
    logic              hilo_write;
  } stage_t;

endpackage

// ===== hdl/mad_if.sv =====
// Interfaces: request and result channels of the multiply/divide unit.
interface mad_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [31:0]        rs_value;
  logic [31:0]        rt_value;
  logic signed [15:0] immediate;
  logic [4:0]         dest_index;

  modport source (output valid, operation, rs_value, rt_value, immediate, dest_index,
                  input ready);
  modport sink   (input valid, operation, rs_value, rt_value, immediate, dest_index,
                  output ready);
endinterface

interface mad_rsp_if;
  logic        valid;
  logic        ready;
  logic        k0_write;
  logic        k0_value;
  logic        gpr_write;
  logic [4:0]  gpr_index;
  logic [31:0] gpr_value;
  logic        hilo_write;
  logic [31:0] hi_value;
  logic [31:0] lo_value;

  modport source (output valid, k0_write, k0_value, gpr_write, gpr_index, gpr_value,
                  hilo_write, hi_value, lo_value, input ready);
  modport sink   (input valid, k0_write, k0_value, gpr_write, gpr_index, gpr_value,
                  hilo_write, hi_value, lo_value, output ready);
endinterface

// ===== hdl/mad_front.sv =====
// Front end: decodes an operation, does add/sub, prepares operand magnitudes.
module mad_front (
  input  logic [2:0]         operation_i,
  input  logic [31:0]        rs_value_i,
  input  logic [31:0]        rt_value_i,
  input  logic signed [15:0] immediate_i,
  input  logic [4:0]         dest_index_i,
  output mad_pkg::entry_t    entry_o
);

  logic [31:0] imm_ext;
  logic [31:0] addend;
  logic [31:0] sum;
  logic        ovf;
  logic        sa;
  logic        sb;
  logic        is_signed;

  assign imm_ext = {{16{immediate_i[15]}}, immediate_i};
  assign sa      = rs_value_i[31];
  assign sb      = rt_value_i[31];

  always_comb begin
    addend = (mad_pkg::op_e'(operation_i) == mad_pkg::OP_ADDI) ? imm_ext : rt_value_i;
    if (mad_pkg::op_e'(operation_i) == mad_pkg::OP_SUB) begin
      sum = rs_value_i - rt_value_i;
      ovf = (sa ^ sb) & (sa ^ sum[31]);
    end else begin
      sum = rs_value_i + addend;
      ovf = (sa ^ sum[31]) & (addend[31] ^ sum[31]);
    end
  end

  always_comb begin
    entry_o            = '0;
    is_signed          = 1'b0;
    case (mad_pkg::op_e'(operation_i))
      mad_pkg::OP_ADD, mad_pkg::OP_SUB, mad_pkg::OP_ADDI: begin
        entry_o.kind      = mad_pkg::KIND_ALU;
        entry_o.k0_write  = 1'b1;
        entry_o.k0_value  = ovf;
        entry_o.gpr_write = ~ovf;
        entry_o.gpr_index = ovf ? 5'd0 : dest_index_i;
        entry_o.gpr_value = ovf ? 32'd0 : sum;
      end
      mad_pkg::OP_MULT, mad_pkg::OP_MULTU: begin
        is_signed          = (mad_pkg::op_e'(operation_i) == mad_pkg::OP_MULT);
        entry_o.kind       = mad_pkg::KIND_MUL;
        entry_o.hilo_write = 1'b1;
        entry_o.neg_lo     = is_signed & (sa ^ sb);
      end
      mad_pkg::OP_DIV, mad_pkg::OP_DIVU: begin
        is_signed          = (mad_pkg::op_e'(operation_i) == mad_pkg::OP_DIV);
        entry_o.kind       = mad_pkg::KIND_DIV;
        entry_o.hilo_write = (rt_value_i != 32'd0);
        entry_o.neg_lo     = is_signed & (sa ^ sb);
        entry_o.neg_hi     = is_signed & sa;
      end
      default: begin
        entry_o.kind = mad_pkg::KIND_NONE;
      end
    endcase
    entry_o.mag_a = (is_signed && sa) ? (32'd0 - rs_value_i) : rs_value_i;
    entry_o.mag_b = (is_signed && sb) ? (32'd0 - rt_value_i) : rt_value_i;
  end

endmodule

// ===== hdl/mad_fifo.sv =====
// Two-entry queue between front end and back end.
module mad_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mad_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mad_pkg::entry_t data_o
);

  localparam int unsigned PW = $clog2(mad_pkg::FIFO_DEPTH);

  mad_pkg::entry_t mem_q [mad_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PW:0]     count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == (PW+1)'(mad_pkg::FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/mad_back.sv =====
// Back end: multiplier stage, radix-2 divider pipeline and sign fixup.
module mad_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  mad_pkg::entry_t entry_i,
  output logic            pop_o,
  mad_rsp_if.source       rsp
);

  localparam int unsigned XL = mad_pkg::XLEN;
  localparam int unsigned NS = mad_pkg::DIV_STAGES;

  mad_pkg::stage_t stg_q [NS+1];
  mad_pkg::stage_t stg_d [NS+1];
  logic [NS:0]     vld_q;
  logic            out_vld_q;
  logic            adv;

  logic [2*XL-1:0] prod_fix;
  logic [XL-1:0]   hi_d, lo_d;

  function automatic logic [2*XL-1:0] div_step(logic [2*XL-1:0] rq, logic [XL-1:0] d);
    logic [XL:0]   t;
    logic [XL:0]   diff;
    logic [XL-1:0] high;
    logic          qbit;
    t    = rq[2*XL-1:XL-1];
    diff = t - {1'b0, d};
    qbit = ~diff[XL];
    high = qbit ? diff[XL-1:0] : t[XL-1:0];
    return {high, rq[XL-2:0], qbit};
  endfunction

  // whole pipeline moves unless a finished result is held
  assign adv   = ~(out_vld_q & ~rsp.ready);
  assign pop_o = adv & valid_i;

  always_comb begin
    stg_d[0].kind       = entry_i.kind;
    stg_d[0].rq         = (entry_i.kind == mad_pkg::KIND_MUL) ?
                          (2*XL)'(entry_i.mag_a) * (2*XL)'(entry_i.mag_b) :
                          {{XL{1'b0}}, entry_i.mag_a};
    stg_d[0].divisor    = entry_i.mag_b;
    stg_d[0].neg_hi     = entry_i.neg_hi;
    stg_d[0].neg_lo     = entry_i.neg_lo;
    stg_d[0].k0_write   = entry_i.k0_write;
    stg_d[0].k0_value   = entry_i.k0_value;
    stg_d[0].gpr_write  = entry_i.gpr_write;
    stg_d[0].gpr_index  = entry_i.gpr_index;
    stg_d[0].gpr_value  = entry_i.gpr_value;
    stg_d[0].hilo_write = entry_i.hilo_write;
  end

  for (genvar k = 1; k <= NS; k++) begin : g_div
    always_comb begin
      stg_d[k] = stg_q[k-1];
      if (stg_q[k-1].kind == mad_pkg::KIND_DIV) begin
        stg_d[k].rq = div_step(stg_q[k-1].rq, stg_q[k-1].divisor);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NS-1:0], valid_i};
      out_vld_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= NS; k++) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // sign fixup on the last stage
  always_comb begin
    prod_fix = stg_q[NS].neg_lo ? ((2*XL)'(0) - stg_q[NS].rq) : stg_q[NS].rq;
    hi_d     = '0;
    lo_d     = '0;
    case (stg_q[NS].kind)
      mad_pkg::KIND_MUL: begin
        hi_d = prod_fix[2*XL-1:XL];
        lo_d = prod_fix[XL-1:0];
      end
      mad_pkg::KIND_DIV: begin
        if (stg_q[NS].hilo_write) begin
          lo_d = stg_q[NS].neg_lo ? (XL'(0) - stg_q[NS].rq[XL-1:0]) : stg_q[NS].rq[XL-1:0];
          hi_d = stg_q[NS].neg_hi ? (XL'(0) - stg_q[NS].rq[2*XL-1:XL])
                                  : stg_q[NS].rq[2*XL-1:XL];
        end
      end
      default: begin
        hi_d = '0;
        lo_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp.k0_write   <= stg_q[NS].k0_write;
      rsp.k0_value   <= stg_q[NS].k0_value;
      rsp.gpr_write  <= stg_q[NS].gpr_write;
      rsp.gpr_index  <= stg_q[NS].gpr_index;
      rsp.gpr_value  <= stg_q[NS].gpr_value;
      rsp.hilo_write <= stg_q[NS].hilo_write;
      rsp.hi_value   <= hi_d;
      rsp.lo_value   <= lo_d;
    end
  end

  assign rsp.valid = out_vld_q;

endmodule

// ===== hdl/mips_arith_mult_div_unit.sv =====
// Top level: MIPS add/sub/addi/mult/multu/div/divu execute unit.
//
// Sustains one transaction per cycle in and out while the output is not
// stalled. Every operation passes through the input queue, the multiplier
// stage, the radix-2 restoring divider pipeline (one quotient bit per stage)
// and the sign-fixup output register. Add, sub and addi ride along the same
// pipeline so results leave in order. A stalled output freezes the back end;
// the request side stays ready until the two-entry queue fills, which in
// steady streaming leaves room for one more transaction.
// Zero divisor gives hilo_write = 0 with HI/LO zero; most-negative / -1 gives
// LO = 0x80000000, HI = 0.
module mips_arith_mult_div_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  mad_req_if.sink   in_i,
  mad_rsp_if.source out_o
);

  mad_pkg::entry_t front_entry;
  mad_pkg::entry_t q_entry;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;

  // classify and do the ALU ops
  mad_front u_front (
    .operation_i  (in_i.operation),
    .rs_value_i   (in_i.rs_value),
    .rt_value_i   (in_i.rt_value),
    .immediate_i  (in_i.immediate),
    .dest_index_i (in_i.dest_index),
    .entry_o      (front_entry)
  );

  assign in_i.ready = ~q_full;

  mad_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_i.valid),
    .data_i  (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_entry)
  );

  mad_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (q_entry),
    .pop_o   (q_pop),
    .rsp     (out_o)
  );

endmodule
